// File: rtl/qnl_pkg.sv
// Shared types and sizing constants for the quaternion nlerp pipeline.
package qnl_pkg;

    localparam int CW      = 16;          // component width, Q2.14
    localparam int WF      = 15;          // weight fraction bits
    localparam int MAG_W   = 31;          // blend magnitude, up to 2^30
    localparam int PROD_W  = 33;          // weight times component
    localparam int P_W     = 34;          // signed blend
    localparam int SQR_W   = 62;          // one square
    localparam int SUM_W   = 63;          // sum of four squares
    localparam int RAD_W   = 64;          // radicand, padded to whole pairs
    localparam int ROOT_W  = 32;
    localparam int REM_W   = 35;
    localparam int INV_W   = 33;
    localparam int DREM_W  = 32;
    localparam int LO_W    = 63;          // magnitude times low word of inverse
    localparam int OUT_SH  = 64 - CW;
    localparam int SQ_STEPS = 32;
    localparam int SQ_PER   = 4;
    localparam int SQ_ST    = SQ_STEPS / SQ_PER;
    localparam int DV_STEPS = 33;
    localparam int DV_PER   = 4;
    localparam int DV_ST    = (DV_STEPS + DV_PER - 1) / DV_PER;
    localparam int NST      = 6 + SQ_ST + DV_ST + 2;

    localparam logic [WF:0] WEIGHT_ONE = (WF + 1)'(1) << WF;

    typedef struct packed {
        logic signed [CW-1:0] a_w;
        logic signed [CW-1:0] a_x;
        logic signed [CW-1:0] a_y;
        logic signed [CW-1:0] a_z;
        logic signed [CW-1:0] b_w;
        logic signed [CW-1:0] b_x;
        logic signed [CW-1:0] b_y;
        logic signed [CW-1:0] b_z;
        logic [CW-1:0]        blend_weight;
    } t_in;

    typedef struct packed {
        logic signed [CW-1:0] out_w;
        logic signed [CW-1:0] out_x;
        logic signed [CW-1:0] out_y;
        logic signed [CW-1:0] out_z;
        logic                 zero_length;
    } t_out;

    // side data that rides alongside the length computation
    typedef struct packed {
        logic                       zero;
        logic [3:0]                 neg;
        logic [3:0][MAG_W-1:0]      mag;
    } t_carry;

endpackage

// File: rtl/quaternion_normalized_lerp.sv
// Throughput: one beat per cycle unless the output stalls; a 4-bit-per-stage
// square root (8 stages) and a 4-bit-per-stage reciprocal divider (9 stages)
// set the depth.
// A stall on the output freezes the whole pipeline; nothing is lost or repeated.
// Reset (synchronous, active low) clears the valid bits only.
module quaternion_normalized_lerp
    import qnl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    logic en;
    logic [NST-1:0] r_vld;

    assign o_stall = r_vld[NST-1] && i_stall;
    assign en      = !o_stall;
    assign o_valid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    // stage 1: weight products
    logic [WF:0] w_t, w_ta;
    logic signed [CW-1:0] w_a [4];
    logic signed [CW-1:0] w_b [4];
    logic signed [PROD_W-1:0] r_pa [4];
    logic signed [PROD_W-1:0] r_pb [4];

    assign w_t  = (i_data.blend_weight[WF:0] > WEIGHT_ONE) ? WEIGHT_ONE
                                                         : i_data.blend_weight[WF:0];
    assign w_ta = WEIGHT_ONE - w_t;
    assign w_a[0] = i_data.a_w;
    assign w_a[1] = i_data.a_x;
    assign w_a[2] = i_data.a_y;
    assign w_a[3] = i_data.a_z;
    assign w_b[0] = i_data.b_w;
    assign w_b[1] = i_data.b_x;
    assign w_b[2] = i_data.b_y;
    assign w_b[3] = i_data.b_z;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r_pa[i] <= $signed({1'b0, w_ta}) * w_a[i];
                r_pb[i] <= $signed({1'b0, w_t}) * w_b[i];
            end
        end
    end

    // stage 2: blend, sign and magnitude
    t_carry n_c2, r_c2;

    always_comb begin
        logic signed [P_W-1:0] p;
        logic [P_W-1:0] ab;
        n_c2.zero = 1'b1;
        n_c2.neg  = '0;
        n_c2.mag  = '0;
        for (int i = 0; i < 4; i++) begin
            p  = $signed({r_pa[i][PROD_W-1], r_pa[i]}) + $signed({r_pb[i][PROD_W-1], r_pb[i]});
            ab = p[P_W-1] ? P_W'(-p) : P_W'(p);
            n_c2.neg[i] = p[P_W-1];
            n_c2.mag[i] = ab[MAG_W-1:0];
            if (p != '0) begin
                n_c2.zero = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c2 <= n_c2;
        end
    end

    // stage 3: squares
    t_carry r_c3;
    logic [SQR_W-1:0] r_sqr [4];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c3 <= r_c2;
            for (int i = 0; i < 4; i++) begin
                r_sqr[i] <= SQR_W'(r_c2.mag[i]) * SQR_W'(r_c2.mag[i]);
            end
        end
    end

    // stage 4: sum of squares
    t_carry r_c4;
    logic [SUM_W-1:0] r_sum4;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c4   <= r_c3;
            r_sum4 <= SUM_W'(r_sqr[0]) + SUM_W'(r_sqr[1]) + SUM_W'(r_sqr[2])
                    + SUM_W'(r_sqr[3]);
        end
    end

    // stages 5 and 6: even normalising shift, magnitudes follow at half the shift
    t_carry n_c5, r_c5, n_c6;
    logic [SUM_W-1:0] n_sum5, r_sum5, n_sum6;

    always_comb begin
        n_sum5 = r_sum4;
        n_c5   = r_c4;
        if (n_sum5 < (SUM_W'(1) << 30)) begin
            n_sum5 = n_sum5 << 32;
            for (int i = 0; i < 4; i++) n_c5.mag[i] = n_c5.mag[i] << 16;
        end
        if (n_sum5 < (SUM_W'(1) << 46)) begin
            n_sum5 = n_sum5 << 16;
            for (int i = 0; i < 4; i++) n_c5.mag[i] = n_c5.mag[i] << 8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c5   <= n_c5;
            r_sum5 <= n_sum5;
        end
    end

    always_comb begin
        n_sum6 = r_sum5;
        n_c6   = r_c5;
        if (n_sum6 < (SUM_W'(1) << 54)) begin
            n_sum6 = n_sum6 << 8;
            for (int i = 0; i < 4; i++) n_c6.mag[i] = n_c6.mag[i] << 4;
        end
        if (n_sum6 < (SUM_W'(1) << 58)) begin
            n_sum6 = n_sum6 << 4;
            for (int i = 0; i < 4; i++) n_c6.mag[i] = n_c6.mag[i] << 2;
        end
        if (n_sum6 < (SUM_W'(1) << 60)) begin
            n_sum6 = n_sum6 << 2;
            for (int i = 0; i < 4; i++) n_c6.mag[i] = n_c6.mag[i] << 1;
        end
    end

    // square root, restoring, two radicand bits per step
    logic [RAD_W-1:0]  r_sq_v    [0:SQ_ST];
    logic [REM_W-1:0]  r_sq_rem  [0:SQ_ST];
    logic [ROOT_W-1:0] r_sq_root [0:SQ_ST];
    t_carry            r_sq_c    [0:SQ_ST];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_v[0]    <= {1'b0, n_sum6};
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_c[0]    <= n_c6;
        end
    end

    for (genvar d = 1; d <= SQ_ST; d++) begin : g_sqrt
        logic [RAD_W-1:0]  n_v;
        logic [REM_W-1:0]  n_rem;
        logic [ROOT_W-1:0] n_root;

        always_comb begin
            logic [REM_W-1:0] trial;
            n_v    = r_sq_v[d-1];
            n_rem  = r_sq_rem[d-1];
            n_root = r_sq_root[d-1];
            for (int s = 0; s < SQ_PER; s++) begin
                n_rem = {n_rem[REM_W-3:0], n_v[RAD_W-1 -: 2]};
                n_v   = n_v << 2;
                trial = REM_W'({n_root, 2'b01});
                if (n_rem >= trial) begin
                    n_rem  = n_rem - trial;
                    n_root = {n_root[ROOT_W-2:0], 1'b1};
                end else begin
                    n_root = {n_root[ROOT_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_v[d]    <= n_v;
                r_sq_rem[d]  <= n_rem;
                r_sq_root[d] <= n_root;
                r_sq_c[d]    <= r_sq_c[d-1];
            end
        end
    end

    // reciprocal 2^62 / root, one quotient bit per step
    logic [DREM_W-1:0] r_dv_rem [1:DV_ST];
    logic [INV_W-1:0]  r_dv_q   [1:DV_ST];
    logic [ROOT_W-1:0] r_dv_s   [1:DV_ST];
    t_carry            r_dv_c   [1:DV_ST];

    for (genvar d = 1; d <= DV_ST; d++) begin : g_div
        logic [DREM_W-1:0] w_rem_in;
        logic [INV_W-1:0]  w_q_in;
        logic [ROOT_W-1:0] w_s_in;
        t_carry            w_c_in;
        logic [DREM_W-1:0] n_rem;
        logic [INV_W-1:0]  n_q;

        if (d == 1) begin : g_first
            // numerator top half: the first step doubles this to 2^30
            assign w_rem_in = DREM_W'(1) << 29;
            assign w_q_in   = '0;
            assign w_s_in   = r_sq_root[SQ_ST];
            assign w_c_in   = r_sq_c[SQ_ST];
        end else begin : g_next
            assign w_rem_in = r_dv_rem[d-1];
            assign w_q_in   = r_dv_q[d-1];
            assign w_s_in   = r_dv_s[d-1];
            assign w_c_in   = r_dv_c[d-1];
        end

        always_comb begin
            logic [DREM_W:0] t2;
            n_rem = w_rem_in;
            n_q   = w_q_in;
            for (int s = 0; s < DV_PER; s++) begin
                if ((d - 1) * DV_PER + s < DV_STEPS) begin
                    t2 = {n_rem, 1'b0};
                    if (t2 >= {1'b0, w_s_in}) begin
                        n_rem = DREM_W'(t2 - {1'b0, w_s_in});
                        n_q   = {n_q[INV_W-2:0], 1'b1};
                    end else begin
                        n_rem = t2[DREM_W-1:0];
                        n_q   = {n_q[INV_W-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_rem[d] <= n_rem;
                r_dv_q[d]   <= n_q;
                r_dv_s[d]   <= w_s_in;
                r_dv_c[d]   <= w_c_in;
            end
        end
    end

    // scale: low 32 bits of the inverse multiplied here, top bit added next
    logic [LO_W-1:0] r_lo [4];
    logic            r_inv_hi;
    t_carry          r_cm;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r_lo[i] <= LO_W'(r_dv_c[DV_ST].mag[i]) * LO_W'(r_dv_q[DV_ST][INV_W-2:0]);
            end
            r_inv_hi <= r_dv_q[DV_ST][INV_W-1];
            r_cm     <= r_dv_c[DV_ST];
        end
    end

    // output: round half up on magnitude, restore sign, identity on zero length
    t_out n_out, r_out;

    always_comb begin
        logic [63:0]   prod;
        logic [CW-1:0] r [4];
        for (int i = 0; i < 4; i++) begin
            prod = {1'b0, r_lo[i]} + (r_inv_hi ? {1'b0, r_cm.mag[i], 32'b0} : 64'd0);
            prod = prod + (64'd1 << (OUT_SH - 1));
            r[i] = prod[OUT_SH +: CW];
            if (r_cm.neg[i]) begin
                r[i] = -r[i];
            end
        end
        if (r_cm.zero) begin
            n_out.out_w       = CW'(1) << (CW - 2);
            n_out.out_x       = '0;
            n_out.out_y       = '0;
            n_out.out_z       = '0;
            n_out.zero_length = 1'b1;
        end else begin
            n_out.out_w       = r[0];
            n_out.out_x       = r[1];
            n_out.out_y       = r[2];
            n_out.out_z       = r[3];
            n_out.zero_length = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_data = r_out;

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the quaternion nlerp pipeline.
module testbench
    import qnl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_in  i_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_out o_data;

    quaternion_normalized_lerp DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    always #5 i_clk = ~i_clk;

    t_out expected_rots[$];
    int   fail_count = 0;
    int   beats_out = 0;
    int   identity_hits = 0;
    bit   calm = 1'b0;        // long stretch without idling on either side

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_out nlerp_predict(input t_in d);
        longint      t;
        longint      p;
        logic [63:0] mag [4];
        bit          neg [4];
        logic [63:0] sum;
        logic [63:0] s;
        logic [63:0] inv;
        logic [63:0] r;
        logic signed [CW-1:0] a [4];
        logic signed [CW-1:0] b [4];
        logic signed [CW-1:0] o [4];
        int          k;
        t_out        res;
        a = '{d.a_w, d.a_x, d.a_y, d.a_z};
        b = '{d.b_w, d.b_x, d.b_y, d.b_z};
        t = longint'(d.blend_weight);
        if (t > 32768) t = 32768;
        sum = 0;
        for (int i = 0; i < 4; i++) begin
            p = (32768 - t) * longint'(a[i]) + t * longint'(b[i]);
            neg[i] = p < 0;
            mag[i] = neg[i] ? 64'(-p) : 64'(p);
            sum += mag[i] * mag[i];
        end
        if (sum == 0) begin
            res = '{out_w: 16'sd16384, out_x: '0, out_y: '0, out_z: '0, zero_length: 1'b1};
            return res;
        end
        k = 0;
        while (sum < (64'd1 << 60)) begin
            sum <<= 2;
            k++;
        end
        s = int_sqrt(sum);
        inv = (64'd1 << 62) / s;
        for (int i = 0; i < 4; i++) begin
            r = (((mag[i] << k) * inv) + (64'd1 << (OUT_SH - 1))) >> OUT_SH;
            o[i] = neg[i] ? CW'(-r) : CW'(r);
        end
        res = '{out_w: o[0], out_x: o[1], out_y: o[2], out_z: o[3], zero_length: 1'b0};
        return res;
    endfunction

    // directed rows: typed expectation only where obvious
    typedef struct {
        t_in  d;
        bit   typed;
        t_out want;
    } t_row;

    t_row rows[$];

    task automatic add_row(input logic [15:0] aw, ax, ay, az, bw, bx, by, bz, wt,
                           input bit typed, input t_out want);
        t_row r;
        r.d = '{aw, ax, ay, az, bw, bx, by, bz, wt};
        r.typed = typed;
        r.want = want;
        rows.push_back(r);
    endtask

    task automatic send_beat(input t_in d, input bit typed, input t_out want);
        if (!calm) begin
            while ($urandom_range(99) < 22) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_data  <= d;
        expected_rots.push_back(typed ? want : nlerp_predict(d));
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(8)) - 16'd4;
            default: return 16'($urandom);
        endcase
    endfunction

    // output side: random stalls, compare against the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= !calm && ($urandom_range(99) < 22);
            if (o_valid && !i_stall) begin
                if (expected_rots.size() == 0) begin
                    $error("output beat with no expectation");
                    fail_count++;
                end else begin
                    t_out e;
                    e = expected_rots.pop_front();
                    beats_out++;
                    if (o_data.zero_length) identity_hits++;
                    if (o_data.out_w !== e.out_w) begin
                        $error("out_w exp %0d got %0d", e.out_w, o_data.out_w);
                        fail_count++;
                    end
                    if (o_data.out_x !== e.out_x) begin
                        $error("out_x exp %0d got %0d", e.out_x, o_data.out_x);
                        fail_count++;
                    end
                    if (o_data.out_y !== e.out_y) begin
                        $error("out_y exp %0d got %0d", e.out_y, o_data.out_y);
                        fail_count++;
                    end
                    if (o_data.out_z !== e.out_z) begin
                        $error("out_z exp %0d got %0d", e.out_z, o_data.out_z);
                        fail_count++;
                    end
                    if (o_data.zero_length !== e.zero_length) begin
                        $error("zero_length exp %0d got %0d", e.zero_length,
                               o_data.zero_length);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial begin
        #2ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        t_out ident;
        t_out unit_w;
        t_out neg_w;
        t_out none;
        t_in  d;
        int   waited;
        ident  = '{out_w: 16'sd16384, out_x: '0, out_y: '0, out_z: '0, zero_length: 1'b1};
        unit_w = '{out_w: 16'sd16384, out_x: '0, out_y: '0, out_z: '0, zero_length: 1'b0};
        neg_w  = '{out_w: -16'sd16384, out_x: '0, out_y: '0, out_z: '0, zero_length: 1'b0};
        none   = '0;
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, ident);                 // zero blend
        add_row(16384, 0, 0, 0, 0, 0, 0, 0, 0, 1, unit_w);
        add_row(0, 0, 0, 0, 16384, 0, 0, 0, 32768, 1, unit_w);
        add_row(0, 0, 0, 0, 16'h8000, 0, 0, 0, 32768, 1, neg_w);
        add_row(16'h7fff, 0, 0, 0, 0, 0, 0, 0, 0, 1, unit_w);
        add_row(16384, 0, 0, 0, 16'hc000, 0, 0, 0, 16384, 1, ident); // cancels out
        add_row(0, 0, 0, 0, 16384, 0, 0, 0, 16'hffff, 1, unit_w);   // weight saturates
        add_row(0, 0, 0, 0, 16384, 0, 0, 0, 16'h8001, 1, unit_w);
        add_row(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0, 0, none);
        add_row(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                16'h8000, 16'h8000, 16'h8000, 16'h8000, 32768, 0, none);
        add_row(16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16384, 0, none);
        add_row(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, none);                  // tiny, heavy shift
        add_row(0, 0, 0, 16'hffff, 0, 1, 0, 0, 1, 0, none);
        add_row(11585, 11585, 0, 0, 0, 0, 11585, 11585, 16384, 0, none);
        add_row(8192, 8192, 8192, 8192, 8192, 8192, 8192, 8192, 32767, 0, none);
        add_row(16'h5555, 16'haaaa, 16'h1234, 16'hedcb,
                16'haaaa, 16'h5555, 16'hedcb, 16'h1234, 16'h7fff, 0, none);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[n]) send_beat(rows[n].d, rows[n].typed, rows[n].want);

        for (int n = 0; n < 450; n++) begin
            calm = (n >= 200 && n < 260);
            d.a_w = rand_comp(); d.a_x = rand_comp();
            d.a_y = rand_comp(); d.a_z = rand_comp();
            if ($urandom_range(9) == 0) begin
                // negated pair at half weight gives a zero blend when no component is 16'h8000
                d.b_w = -d.a_w; d.b_x = -d.a_x; d.b_y = -d.a_y; d.b_z = -d.a_z;
                if (d.a_w == 16'h8000 || d.a_x == 16'h8000 ||
                    d.a_y == 16'h8000 || d.a_z == 16'h8000) d.a_w = 0;
                if (d.a_w == 0) d.b_w = 0;
                d.blend_weight = 16384;
            end else begin
                d.b_w = rand_comp(); d.b_x = rand_comp();
                d.b_y = rand_comp(); d.b_z = rand_comp();
                case ($urandom_range(5))
                    0: d.blend_weight = 0;
                    1: d.blend_weight = 32768;
                    2: d.blend_weight = 16'($urandom);
                    default: d.blend_weight = 16'($urandom_range(32768));
                endcase
            end
            send_beat(d, 1'b0, none);
        end
        calm = 1'b0;
        i_valid <= 1'b0;

        waited = 0;
        while (expected_rots.size() != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_rots.size() != 0) begin
            $error("%0d beats never came out", expected_rots.size());
            fail_count++;
        end
        repeat (40) @(posedge i_clk);

        $display("Blended %0d quaternion pairs, %0d of them zero-length identities.",
                 beats_out, identity_hits);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
